@@ src/bta_pkg.sv @@
// Shared constants of the boundary-tag block allocator.
package bta_pkg;

  localparam int META      = 4;
  localparam int TAG_FREE  = 0;
  localparam int TAG_ALLOC = 1;

  localparam logic CMD_REQ = 1'b0;
  localparam logic CMD_REL = 1'b1;

  localparam logic [1:0] STRAT_FIRST = 2'd0;
  localparam logic [1:0] STRAT_NEXT  = 2'd1;
  localparam logic [1:0] STRAT_BEST  = 2'd2;
  localparam logic [1:0] STRAT_WORST = 2'd3;

endpackage

@@ src/bta_ram.sv @@
// Generic single-port RAM with registered read.
module bta_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ src/boundary_tag_block_allocator_top.sv @@
// Boundary-tag block allocator: list walker and block store.
//
// Command channel: a word is taken at a rising edge with start high and busy
// low. cmd 0 requests size_bytes rounded up to words using strategy (first,
// next, best or worst fit); cmd 1 releases the block whose header sits at
// block_addr. Every command gives one result word, shown for exactly one
// cycle with done high: alloc_addr, fail, cost and used_words.
// The receiver cannot stall; busy drops in the cycle that shows the result.
// A request walks the block list in the store through one single-port RAM,
// with three reads and a decision per block visited, then carves the block
// and posts the result. A release walks the list to check the header, then
// does the reads and writes for the merges and the result.
// Throughput is one command at a time; the RAM port sets the pace.
// After reset the store is cleared to one free block spanning all words in a
// pass that writes every word, with busy high; the next-fit cursor, the cost
// and the word count start at zero.
module boundary_tag_block_allocator_top
  import bta_pkg::*;
#(
  parameter int MEM_WORDS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [11:0] size_bytes,
  input  logic [1:0]  strategy,
  input  logic [9:0]  block_addr,
  output logic        done,
  output logic [9:0]  alloc_addr,
  output logic        fail,
  output logic [9:0]  cost,
  output logic [10:0] used_words
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam int DW = AW + 1;
  localparam int CW = (AW + 3 > 12) ? AW + 3 : 12;

  localparam logic [CW-1:0] C_MW   = CW'(MEM_WORDS);
  localparam logic [CW-1:0] C_META = CW'(META);
  localparam logic [CW-1:0] C_ONE  = CW'(1);
  localparam logic [CW-1:0] C_TWO  = CW'(2);
  localparam logic [CW-1:0] C_THR  = CW'(3);
  localparam logic [CW-1:0] C_FREE = CW'(TAG_FREE);

  localparam logic [5:0] S_CLR = 6'd0,  S_IDLE = 6'd1,  S_V0 = 6'd2,   S_V1 = 6'd3;
  localparam logic [5:0] S_V2 = 6'd4,   S_V3 = 6'd5,    S_DEC = 6'd6,  S_CV = 6'd7;
  localparam logic [5:0] S_CW1 = 6'd8,  S_CW2 = 6'd9,   S_CW3 = 6'd10, S_CW4 = 6'd11;
  localparam logic [5:0] S_CW5 = 6'd12, S_CW6 = 6'd13,  S_CW7 = 6'd14, S_CW8 = 6'd15;
  localparam logic [5:0] S_F0 = 6'd16,  S_F1 = 6'd17,   S_F2 = 6'd18,  S_F3 = 6'd19;
  localparam logic [5:0] S_F4 = 6'd20,  S_F5 = 6'd21,   S_A0 = 6'd22,  S_A1 = 6'd23;
  localparam logic [5:0] S_A6 = 6'd24,  S_A7 = 6'd25,   S_A8 = 6'd26,  S_B0 = 6'd27;
  localparam logic [5:0] S_M1 = 6'd28,  S_M2 = 6'd29,   S_M3 = 6'd30,  S_M4 = 6'd31;
  localparam logic [5:0] S_C0 = 6'd32,  S_C1 = 6'd33,   S_C2 = 6'd34,  S_C3 = 6'd35;
  localparam logic [5:0] S_C4 = 6'd36,  S_C5 = 6'd37,   S_C9 = 6'd38,  S_D0 = 6'd39;
  localparam logic [5:0] S_FIN = 6'd40;

  localparam logic [2:0] R_FIRST = 3'd0, R_NEXT = 3'd1, R_BW = 3'd2;
  localparam logic [2:0] R_CHK = 3'd3, R_MRG = 3'd4;

  logic [5:0]    st, mnext;
  logic [2:0]    ret;
  logic [AW-1:0] clr;
  logic [1:0]    strat_q;
  logic [9:0]    addr_q;
  logic [CW-1:0] words, cur, cnt;
  logic [CW-1:0] vsize, vtag, vsucc;
  logic          stop_v, pick_v;
  logic [CW-1:0] stop, pick, pick_size, pick_succ;
  logic [CW-1:0] loc, lsucc, fh, spm, succ2;
  logic          split;
  logic [CW-1:0] pred, psz, gap, h, hsz, hsucc, res_alloc;
  logic          res_fail;
  logic [AW-1:0] cursor;
  logic [9:0]    last_cost;
  logic [AW:0]   in_use;
  logic          rd_oob;

  logic [CW-1:0] ma;
  logic          mwe, oob;
  logic [DW-1:0] mwd, ram_q;
  logic [CW-1:0] rdx;

  logic          fits, better;
  logic [CW-1:0] c_end, c_fh, pe, te;

  bta_ram #(.WIDTH(DW), .DEPTH(MEM_WORDS)) u_ram (
    .clk   (clk),
    .we    (mwe && !oob),
    .addr  (ma[AW-1:0]),
    .wdata (mwd),
    .rdata (ram_q)
  );

  assign oob  = (ma >= C_MW);
  assign rdx  = rd_oob ? '0 : CW'(ram_q);
  assign busy = (st != S_IDLE);

  assign fits   = (vtag == C_FREE) && (vsize >= words);
  assign better = fits && (!pick_v || ((strat_q == STRAT_BEST) ? (vsize < pick_size)
                                                               : (vsize > pick_size)));
  assign c_end  = (lsucc != loc) ? lsucc : C_MW;
  assign c_fh   = loc + words + C_META;
  assign pe     = pred + rdx + C_META;
  assign te     = h + hsz + C_META;

  always_comb begin
    ma  = '0;
    mwe = 1'b0;
    mwd = '0;
    unique case (st)
      S_CLR: begin
        ma  = CW'(clr);
        mwe = 1'b1;
        mwd = (clr == AW'(1)) ? DW'(MEM_WORDS - META) : '0;
      end
      S_V0:  ma = cur + C_ONE;
      S_V1:  ma = cur + rdx + C_TWO;
      S_V2:  ma = cur + vsize + C_THR;
      S_CW1: begin ma = loc + C_ONE; mwe = 1'b1; mwd = DW'(words); end
      S_CW2: begin ma = loc + words + C_TWO; mwe = 1'b1; mwd = DW'(TAG_ALLOC); end
      S_CW3: begin
        ma  = loc + words + C_THR;
        mwe = 1'b1;
        mwd = split ? DW'(fh) : DW'(lsucc);
      end
      S_CW4: begin ma = fh; mwe = 1'b1; mwd = DW'(loc); end
      S_CW5: begin ma = fh + C_ONE; mwe = 1'b1; mwd = DW'(spm); end
      S_CW6: begin ma = fh + spm + C_TWO; mwe = 1'b1; mwd = DW'(TAG_FREE); end
      S_CW7: begin ma = fh + spm + C_THR; mwe = 1'b1; mwd = DW'(succ2); end
      S_CW8: begin ma = succ2; mwe = 1'b1; mwd = DW'(fh); end
      S_F0:  begin ma = h + hsz + C_TWO; mwe = 1'b1; mwd = DW'(TAG_FREE); end
      S_F1:  ma = h;
      S_F3:  ma = pred + C_ONE;
      S_F4:  ma = pred + rdx + C_TWO;
      S_A0:  ma = pred;
      S_A7:  ma = pred + C_ONE;
      S_A8:  begin ma = pred + rdx + C_THR; mwe = 1'b1; mwd = DW'(h); end
      S_M1:  begin ma = h + C_ONE; mwe = 1'b1; mwd = DW'(hsz); end
      S_M2:  begin ma = h + hsz + C_TWO; mwe = 1'b1; mwd = DW'(TAG_FREE); end
      S_M3:  begin ma = h + hsz + C_THR; mwe = 1'b1; mwd = DW'(hsucc); end
      S_M4:  begin ma = hsucc; mwe = 1'b1; mwd = DW'(h); end
      S_C0:  ma = h;
      S_C2:  ma = pred + C_ONE;
      S_C4:  begin ma = hsucc; mwe = (hsucc != h); mwd = DW'(h - gap); end
      S_C5:  begin ma = h; mwe = 1'b1; mwd = DW'(pred); end
      S_C9:  begin ma = pred + psz + C_THR; mwe = 1'b1; mwd = DW'(h); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_oob <= oob;
    if (rst) begin
      st        <= S_CLR;
      clr       <= '0;
      cursor    <= '0;
      last_cost <= '0;
      in_use    <= '0;
      done      <= 1'b0;
    end else begin
      done <= (st == S_FIN);
      unique case (st)
        S_CLR: begin
          clr <= clr + AW'(1);
          if (clr == AW'(MEM_WORDS - 1)) st <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            strat_q   <= strategy;
            addr_q    <= block_addr;
            words     <= CW'((13'(size_bytes) + 13'd3) >> 2);
            cnt       <= C_ONE;
            stop_v    <= 1'b0;
            pick_v    <= 1'b0;
            res_alloc <= '0;
            res_fail  <= 1'b0;
            st        <= S_V0;
            cur       <= (cmd == CMD_REQ && strategy == STRAT_NEXT) ? CW'(cursor) : '0;
            if (cmd == CMD_REL) begin
              ret <= R_CHK;
            end else begin
              unique case (strategy)
                STRAT_FIRST: ret <= R_FIRST;
                STRAT_NEXT: ret <= R_NEXT;
                STRAT_BEST, STRAT_WORST: ret <= R_BW;
                default: ret <= R_FIRST;
              endcase
            end
          end
        end
        S_V0: st <= S_V1;
        S_V1: begin vsize <= rdx; st <= S_V2; end
        S_V2: begin vtag <= rdx; st <= S_V3; end
        S_V3: begin vsucc <= rdx; st <= S_DEC; end
        S_DEC: begin
          unique case (ret)
            R_FIRST: begin
              if (fits) begin
                loc <= cur; lsucc <= vsucc; st <= S_CV;
              end else begin
                cnt <= cnt + C_ONE;
                if (vsucc == cur) begin
                  res_fail <= 1'b1; st <= S_FIN;
                end else begin
                  cur <= vsucc; st <= S_V0;
                end
              end
            end
            R_NEXT: begin
              if (fits) begin
                loc <= cur; lsucc <= vsucc; st <= S_CV;
              end else begin
                cnt <= cnt + C_ONE;
                if (stop_v && stop == cur) begin
                  res_fail <= 1'b1; st <= S_FIN;
                end else begin
                  stop_v <= 1'b1;
                  if (!stop_v) stop <= cur;
                  if (vsucc == cur) begin
                    if (cur == '0) begin
                      res_fail <= 1'b1; st <= S_FIN;
                    end else begin
                      cur <= '0; st <= S_V0;
                    end
                  end else begin
                    cur <= vsucc; st <= S_V0;
                  end
                end
              end
            end
            R_BW: begin
              cnt <= cnt + C_ONE;
              if (better) begin
                pick <= cur; pick_size <= vsize; pick_succ <= vsucc; pick_v <= 1'b1;
              end
              if (vsucc == cur) begin
                if (better) begin
                  loc <= cur; lsucc <= vsucc; st <= S_CV;
                end else if (pick_v) begin
                  loc <= pick; lsucc <= pick_succ; st <= S_CV;
                end else begin
                  res_fail <= 1'b1; st <= S_FIN;
                end
              end else begin
                cur <= vsucc; st <= S_V0;
              end
            end
            R_CHK: begin
              if (cur == CW'(addr_q)) begin
                if (vtag == CW'(TAG_ALLOC)) begin
                  h <= cur; hsz <= vsize; hsucc <= vsucc; st <= S_F0;
                end else begin
                  st <= S_FIN;
                end
              end else if (vsucc == cur) begin
                st <= S_FIN;
              end else begin
                cur <= vsucc; st <= S_V0;
              end
            end
            R_MRG: begin
              if (vtag == C_FREE) begin
                hsz   <= hsz + vsize + C_META;
                hsucc <= (vsucc == cur) ? h : vsucc;
                if (CW'(cursor) == cur) cursor <= AW'(h);
                mnext <= S_C0;
                st    <= S_M1;
              end else begin
                st <= S_C0;
              end
            end
            default: st <= S_FIN;
          endcase
        end
        S_CV: begin
          split     <= (c_end >= c_fh + C_META);
          spm       <= c_end - c_fh - C_META;
          fh        <= c_fh;
          succ2     <= (lsucc < c_fh) ? c_fh : lsucc;
          cursor    <= (c_end >= c_fh + C_META) ? AW'(c_fh) : AW'(lsucc);
          in_use    <= in_use + (AW + 1)'(words + C_META);
          last_cost <= 10'(cnt);
          res_alloc <= loc;
          st        <= S_CW1;
        end
        S_CW1: st <= S_CW2;
        S_CW2: st <= S_CW3;
        S_CW3: st <= split ? S_CW4 : S_FIN;
        S_CW4: st <= S_CW5;
        S_CW5: st <= S_CW6;
        S_CW6: st <= S_CW7;
        S_CW7: st <= (succ2 != fh) ? S_CW8 : S_FIN;
        S_CW8: st <= S_FIN;
        S_F0: begin
          in_use <= in_use - (AW + 1)'(hsz + C_META);
          st     <= S_F1;
        end
        S_F1: st <= S_F2;
        S_F2: begin
          pred <= rdx;
          st   <= (rdx != h) ? S_F3 : S_B0;
        end
        S_F3: st <= S_F4;
        S_F4: begin psz <= rdx; st <= S_F5; end
        S_F5: st <= (rdx == C_FREE) ? S_A0 : S_B0;
        S_A0: st <= S_A1;
        S_A1: begin
          h     <= pred;
          pred  <= rdx;
          hsz   <= psz + hsz + C_META;
          hsucc <= (hsucc == h) ? pred : hsucc;
          if (CW'(cursor) == h) cursor <= AW'(pred);
          mnext <= S_A6;
          st    <= S_M1;
        end
        S_A6: st <= (pred != h) ? S_A7 : S_B0;
        S_A7: st <= S_A8;
        S_A8: st <= S_B0;
        S_B0: begin
          if (hsucc != h) begin
            cur <= hsucc; ret <= R_MRG; st <= S_V0;
          end else begin
            st <= S_C0;
          end
        end
        S_M1: st <= S_M2;
        S_M2: st <= S_M3;
        S_M3: st <= (hsucc != h) ? S_M4 : mnext;
        S_M4: st <= mnext;
        S_C0: st <= S_C1;
        S_C1: begin
          pred <= rdx;
          st   <= (rdx != h) ? S_C2 : S_D0;
        end
        S_C2: st <= S_C3;
        S_C3: begin
          psz <= rdx;
          gap <= h - pe;
          st  <= (h > pe && h < pe + C_META) ? S_C4 : S_D0;
        end
        S_C4: begin
          hsucc <= (hsucc == h) ? (h - gap) : hsucc;
          hsz   <= hsz + gap;
          h     <= h - gap;
          if (CW'(cursor) == h) cursor <= AW'(h - gap);
          st    <= S_C5;
        end
        S_C5: begin mnext <= S_C9; st <= S_M1; end
        S_C9: st <= S_D0;
        S_D0: begin
          if (hsucc == h && C_MW > te && C_MW < te + C_META) begin
            hsz   <= hsz + (C_MW - te);
            mnext <= S_FIN;
            st    <= S_M1;
          end else begin
            st <= S_FIN;
          end
        end
        S_FIN: begin
          alloc_addr <= 10'(res_alloc);
          fail       <= res_fail;
          cost       <= last_cost;
          used_words <= 11'(in_use);
          st         <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

@@ bench/tb_boundary_tag_block_allocator_top.sv @@
// Self-checking testbench for the boundary-tag block allocator top level.
`timescale 1ns / 100ps

module tb_boundary_tag_block_allocator_top;
  import bta_pkg::*;

  localparam int MEM_WORDS = 1024;
  localparam int N_RANDOM  = 1600;
  localparam int QUIET_TAIL = 200;

  typedef struct packed {
    logic [9:0]  alloc_addr;
    logic        fail;
    logic [9:0]  cost;
    logic [10:0] used_words;
  } alloc_word_t;

  typedef struct {
    logic        cmd;
    logic [11:0] size_bytes;
    logic [1:0]  strategy;
    logic [9:0]  block_addr;
    bit          typed;
    alloc_word_t want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        cmd;
  logic [11:0] size_bytes;
  logic [1:0]  strategy;
  logic [9:0]  block_addr;
  logic        done;
  logic [9:0]  alloc_addr;
  logic        fail;
  logic [9:0]  cost;
  logic [10:0] used_words;

  int          store_mdl [MEM_WORDS];
  int          cursor_mdl;
  int          cost_mdl;
  int          used_mdl;
  alloc_word_t pending_words [$];
  int          live_blocks [$];
  int          mismatches;

  boundary_tag_block_allocator_top #(.MEM_WORDS(MEM_WORDS)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .size_bytes(size_bytes), .strategy(strategy), .block_addr(block_addr),
    .done(done), .alloc_addr(alloc_addr), .fail(fail), .cost(cost),
    .used_words(used_words)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int rd(int i);
    if (i < 0 || i >= MEM_WORDS) return 0;
    return store_mdl[i];
  endfunction

  function automatic void wr(int i, int v);
    if (i >= 0 && i < MEM_WORDS) store_mdl[i] = v;
  endfunction

  function automatic int bsize(int p);
    return rd(p + 1);
  endfunction

  function automatic int btag(int p);
    return rd(p + bsize(p) + 2);
  endfunction

  function automatic int bsucc(int p);
    return rd(p + bsize(p) + 3);
  endfunction

  function automatic void set_succ(int p, int s);
    wr(p + bsize(p) + 3, s);
  endfunction

  function automatic void put_blk(int p, int pred, int sz, int tag, int succ);
    wr(p, pred);
    wr(p + 1, sz);
    wr(p + sz + 2, tag);
    wr(p + sz + 3, succ);
  endfunction

  function automatic bit fits(int p, int words);
    return btag(p) == TAG_FREE && bsize(p) >= words;
  endfunction

  function automatic bit is_allocated(int a);
    int cur;
    int s;
    cur = 0;
    for (int n = 0; n < MEM_WORDS; n++) begin
      if (cur == a) return btag(cur) == TAG_ALLOC;
      s = bsucc(cur);
      if (s == cur) return 0;
      cur = s;
    end
    return 0;
  endfunction

  function automatic int find_free(int words, logic [1:0] strat, output int c);
    int cur;
    int stop;
    int s;
    int pick;
    int pick_size;
    int last;
    int sz;
    c = 1;
    if (strat == STRAT_NEXT) begin
      stop = -1;
      cur = cursor_mdl;
      for (int n = 0; n < MEM_WORDS && !fits(cur, words); n++) begin
        c++;
        if (stop < 0) stop = cur;
        else if (stop == cur) break;
        s = bsucc(cur);
        if (s == cur) begin
          if (cur == 0) break;
          cur = 0;
        end else begin
          cur = s;
        end
      end
      return fits(cur, words) ? cur : -1;
    end
    if (strat == STRAT_FIRST) begin
      cur = 0;
      for (int n = 0; n < MEM_WORDS && !fits(cur, words); n++) begin
        c++;
        s = bsucc(cur);
        if (s == cur) return -1;
        cur = s;
      end
      return fits(cur, words) ? cur : -1;
    end
    pick = -1;
    pick_size = 0;
    last = -1;
    cur = 0;
    for (int n = 0; n < MEM_WORDS && cur != last; n++) begin
      c++;
      if (fits(cur, words)) begin
        sz = bsize(cur);
        if (pick < 0 || (strat == STRAT_BEST ? sz < pick_size : sz > pick_size)) begin
          pick = cur;
          pick_size = sz;
        end
      end
      last = cur;
      cur = bsucc(cur);
    end
    return pick;
  endfunction

  function automatic void carve(int loc, int words);
    int pred;
    int succ;
    int stop_at;
    int space;
    int fh;
    pred = rd(loc);
    succ = bsucc(loc);
    stop_at = (succ != loc) ? succ : MEM_WORDS;
    space = stop_at - (loc + words + META);
    if (space < 4) begin
      put_blk(loc, pred, words, TAG_ALLOC, succ);
    end else begin
      fh = loc + META + words;
      put_blk(loc, pred, words, TAG_ALLOC, fh);
      if (succ < fh) succ = fh;
      put_blk(fh, loc, space - META, TAG_FREE, succ);
      if (succ != fh) wr(succ, fh);
    end
    cursor_mdl = bsucc(loc);
    used_mdl += words + META;
  endfunction

  function automatic void release_blk(int h);
    int pred;
    int succ;
    int gone;
    int after;
    int ns;
    int gap;
    int np;
    int s;
    int sz;
    int tail;
    used_mdl -= bsize(h) + META;
    wr(h + bsize(h) + 2, TAG_FREE);
    pred = rd(h);
    succ = bsucc(h);
    if (pred != h && btag(pred) == TAG_FREE) begin
      if (succ == h) succ = pred;
      put_blk(pred, rd(pred), bsize(pred) + bsize(h) + META, TAG_FREE, succ);
      if (cursor_mdl == h) cursor_mdl = pred;
      h = pred;
      succ = bsucc(h);
      if (succ != h) wr(succ, h);
      pred = rd(h);
      if (pred != h) set_succ(pred, h);
    end
    if (succ != h && btag(succ) == TAG_FREE) begin
      gone = succ;
      after = bsucc(gone);
      ns = (after == gone) ? h : after;
      put_blk(h, pred, bsize(h) + bsize(gone) + META, TAG_FREE, ns);
      if (cursor_mdl == gone) cursor_mdl = h;
      if (ns != h) wr(ns, h);
    end
    pred = rd(h);
    if (pred != h) begin
      gap = h - (pred + META + bsize(pred));
      if (gap > 0 && gap < 4) begin
        np = h - gap;
        s = bsucc(h);
        sz = bsize(h);
        if (s == h) s = np;
        else wr(s, np);
        put_blk(np, pred, sz + gap, TAG_FREE, s);
        if (cursor_mdl == h) cursor_mdl = np;
        h = np;
        set_succ(pred, h);
      end
    end
    if (bsucc(h) == h) begin
      sz = bsize(h);
      tail = MEM_WORDS - (h + sz + META);
      if (tail > 0 && tail < 4) put_blk(h, rd(h), sz + tail, TAG_FREE, h);
    end
  endfunction

  function automatic void clear_store();
    foreach (store_mdl[i]) store_mdl[i] = 0;
    put_blk(0, 0, MEM_WORDS - META, TAG_FREE, 0);
    cursor_mdl = 0;
    cost_mdl = 0;
    used_mdl = 0;
  endfunction

  function automatic alloc_word_t apply_word(logic c, logic [11:0] nbytes,
                                             logic [1:0] strat, logic [9:0] addr);
    alloc_word_t r;
    int words;
    int c_walk;
    int loc;
    r = '0;
    if (c == CMD_REQ) begin
      words = (int'(nbytes) + 3) / 4;
      loc = find_free(words, strat, c_walk);
      if (loc < 0) begin
        r.fail = 1'b1;
      end else begin
        carve(loc, words);
        cost_mdl = c_walk;
        r.alloc_addr = loc[9:0];
        live_blocks.push_back(loc);
      end
    end else if (is_allocated(int'(addr))) begin
      release_blk(int'(addr));
      foreach (live_blocks[i]) begin
        if (live_blocks[i] == int'(addr)) begin
          live_blocks.delete(i);
          break;
        end
      end
    end
    r.cost = cost_mdl[9:0];
    r.used_words = used_mdl[10:0];
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    alloc_word_t w;
    if (!rst && done) begin
      if (pending_words.size() == 0) begin
        report("unexpected word, alloc_addr", alloc_addr, 0);
      end else begin
        w = pending_words.pop_front();
        if (alloc_addr !== w.alloc_addr) report("alloc_addr", alloc_addr, w.alloc_addr);
        if (fail !== w.fail) report("fail", fail, w.fail);
        if (cost !== w.cost) report("cost", cost, w.cost);
        if (used_words !== w.used_words) report("used_words", used_words, w.used_words);
      end
    end
  end

  task automatic send_word(logic c, logic [11:0] nbytes, logic [1:0] strat,
                           logic [9:0] addr, bit typed, alloc_word_t want);
    alloc_word_t p;
    cmd <= c;
    size_bytes <= nbytes;
    strategy <= strat;
    block_addr <= addr;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    p = apply_word(c, nbytes, strat, addr);
    pending_words.push_back(typed ? want : p);
  endtask

  task automatic hold_off(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  stim_row_t rows [] = '{
    '{CMD_REQ, 12'd0,    STRAT_FIRST, 10'd0,    1, '{10'd0, 1'b0, 10'd1, 11'd4}},
    '{CMD_REQ, 12'd4092, STRAT_WORST, 10'd0,    1, '{10'd0, 1'b1, 10'd1, 11'd4}},
    '{CMD_REL, 12'd0,    STRAT_FIRST, 10'd1023, 1, '{10'd0, 1'b0, 10'd1, 11'd4}},
    '{CMD_REQ, 12'd4,    STRAT_NEXT,  10'd0,    1, '{10'd4, 1'b0, 10'd1, 11'd9}},
    '{CMD_REQ, 12'd5,    STRAT_BEST,  10'd0,    0, '{10'd0, 1'b0, 10'd0, 11'd0}},
    '{CMD_REQ, 12'd3,    STRAT_WORST, 10'd0,    0, '{10'd0, 1'b0, 10'd0, 11'd0}},
    '{CMD_REQ, 12'd1,    STRAT_FIRST, 10'd0,    0, '{10'd0, 1'b0, 10'd0, 11'd0}},
    '{CMD_REL, 12'd0,    STRAT_FIRST, 10'd4,    0, '{10'd0, 1'b0, 10'd0, 11'd0}},
    '{CMD_REL, 12'd0,    STRAT_FIRST, 10'd4,    0, '{10'd0, 1'b0, 10'd0, 11'd0}},
    '{CMD_REL, 12'd0,    STRAT_FIRST, 10'd9,    0, '{10'd0, 1'b0, 10'd0, 11'd0}},
    '{CMD_REQ, 12'd2,    STRAT_NEXT,  10'd0,    0, '{10'd0, 1'b0, 10'd0, 11'd0}},
    '{CMD_REQ, 12'd4000, STRAT_FIRST, 10'd0,    0, '{10'd0, 1'b0, 10'd0, 11'd0}},
    '{CMD_REQ, 12'd4092, STRAT_NEXT,  10'd0,    0, '{10'd0, 1'b0, 10'd0, 11'd0}},
    '{CMD_REL, 12'd0,    STRAT_WORST, 10'd0,    0, '{10'd0, 1'b0, 10'd0, 11'd0}},
    '{CMD_REL, 12'd4095, STRAT_BEST,  10'd682,  0, '{10'd0, 1'b0, 10'd0, 11'd0}},
    '{CMD_REQ, 12'd4047, STRAT_BEST,  10'd341,  0, '{10'd0, 1'b0, 10'd0, 11'd0}},
    '{CMD_REQ, 12'd20,   STRAT_WORST, 10'd0,    0, '{10'd0, 1'b0, 10'd0, 11'd0}}
  };

  initial begin
    int wait_cycles;
    int rel_pct;
    logic c;
    logic [11:0] nb;
    logic [9:0] addr;
    mismatches = 0;
    rst = 1'b1;
    start = 1'b0;
    cmd = CMD_REQ;
    size_bytes = '0;
    strategy = STRAT_FIRST;
    block_addr = '0;
    clear_store();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      send_word(rows[i].cmd, rows[i].size_bytes, rows[i].strategy,
                rows[i].block_addr, rows[i].typed, rows[i].want);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) begin
        start <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
      end
      if (n < N_RANDOM - QUIET_TAIL && $urandom_range(0, 4) == 0)
        hold_off($urandom_range(1, 14));
      addr = 10'($urandom_range(0, 1023));
      c = CMD_REQ;
      rel_pct = (live_blocks.size() > 40) ? 65 : 40;
      if (live_blocks.size() > 0 && $urandom_range(0, 99) < rel_pct) begin
        c = CMD_REL;
        addr = 10'(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
      end else if ($urandom_range(0, 19) == 0) begin
        c = CMD_REL;
      end
      case ($urandom_range(0, 9))
        0: nb = 12'($urandom_range(0, 4095));
        1, 2: nb = 12'($urandom_range(0, 400));
        default: nb = 12'($urandom_range(0, 64));
      endcase
      send_word(c, nb, 2'($urandom_range(0, 3)), addr, 0, '0);
    end
    start <= 1'b0;

    wait_cycles = 0;
    while (pending_words.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
